// ===== sv/interval_gap_reservation_assert.svh =====
// Assertion macros for the interval gap reservation checker
`ifndef INTERVAL_GAP_RESERVATION_ASSERT_SVH
`define INTERVAL_GAP_RESERVATION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define IGR_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interval gap reservation check failed");

// Consequent must hold in the cycle after the antecedent
`define IGR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interval gap reservation check failed");

`endif

// ===== sv/igr_pkg.sv =====
// Shared types and codes for the interval gap reservation block
package igr_pkg;

  localparam int unsigned ModeBits   = 2;
  localparam int unsigned StatusBits = 2;

  // Operation carried by an input item
  typedef enum logic [ModeBits-1:0] {
    MODE_QUERY   = 2'd0,
    MODE_RESERVE = 2'd1,
    MODE_CLEAR   = 2'd2
  } igr_mode_e;

  // Outcome reported with each result item
  typedef enum logic [StatusBits-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } igr_status_e;

  // Per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic eval;   // compare held interval against bound and predecessor gap
    logic fit;    // form the gap candidate flag
    logic ins;    // insert: cells after the slot shift up, slot cell loads
    logic merge;  // extend the interval just before the slot
  } igr_cell_ctrl_t;

endpackage

// ===== sv/igr_cell.sv =====
// One table cell: holds a busy interval, evaluates it and shifts with its neighbour
module igr_cell import igr_pkg::*; #(
  parameter int unsigned Index    = 0,
  parameter int unsigned TimeBits = 32,
  parameter int unsigned CntBits  = 7
) (
  input  logic                clk_i,
  input  igr_cell_ctrl_t      ctrl_i,
  input  logic [CntBits-1:0]  used_i,
  input  logic [CntBits-1:0]  first_i,
  input  logic [TimeBits-1:0] bound_i,
  input  logic [TimeBits-1:0] len_i,
  input  logic [TimeBits-1:0] p1_i,
  input  logic [TimeBits-1:0] new_start_i,
  input  logic [TimeBits-1:0] new_end_i,
  input  logic [TimeBits-1:0] prev_start_i,
  input  logic [TimeBits-1:0] prev_end_i,
  input  logic                is_k1_i,
  input  logic                after_k1_i,
  input  logic                is_cur_i,
  input  logic                after_cur_i,
  input  logic                next_is_cur_i,
  output logic [TimeBits-1:0] start_o,
  output logic [TimeBits-1:0] end_o,
  output logic                sel1_o,
  output logic                cand_o
);

  localparam logic [CntBits-1:0] IdxC = CntBits'(Index);

  logic [TimeBits-1:0] start_q, end_q;
  logic                sel1_q, sel1_d;
  logic                fit_q, fit_d;
  logic                cand_q, cand_d;
  logic [TimeBits-1:0] diff_prev, diff_p1;
  logic                valid;

  // Local comparisons; only entries below the fill count take part
  always_comb begin
    valid     = IdxC < used_i;
    diff_prev = start_q - prev_end_i;
    diff_p1   = start_q - p1_i;
    sel1_d    = valid && (IdxC >= first_i) && (start_q >= bound_i);
    fit_d     = (start_q >= prev_end_i) && (diff_prev >= len_i);
    cand_d    = valid && ((is_k1_i && (start_q >= p1_i) && (diff_p1 >= len_i)) ||
                          (after_k1_i && fit_q));
  end

  // Search flags
  always_ff @(posedge clk_i) begin
    if (ctrl_i.eval) begin
      sel1_q <= sel1_d;
      fit_q  <= fit_d;
    end
    if (ctrl_i.fit) begin
      cand_q <= cand_d;
    end
  end

  // Interval storage: shift up, load the new interval or extend on merge
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins && after_cur_i) begin
      start_q <= prev_start_i;
      end_q   <= prev_end_i;
    end else if (ctrl_i.ins && is_cur_i) begin
      start_q <= new_start_i;
      end_q   <= new_end_i;
    end else if (ctrl_i.merge && next_is_cur_i) begin
      end_q   <= new_end_i;
    end
  end

  assign start_o = start_q;
  assign end_o   = end_q;
  assign sel1_o  = sel1_q;
  assign cand_o  = cand_q;

endmodule

// ===== sv/igr_sel.sv =====
// First-set select over the cell row: one-hot, index and predecessor finish time
module igr_sel #(
  parameter int unsigned Positions = 65,
  parameter int unsigned TimeBits  = 32,
  parameter int unsigned IdxBits   = 7
) (
  input  logic [Positions-1:0]               flags_i,
  input  logic [Positions-1:0][TimeBits-1:0] vals_i,
  output logic [Positions-1:0]               first_o,
  output logic [Positions-1:0]               after_o,
  output logic [IdxBits-1:0]                 idx_o,
  output logic [TimeBits-1:0]                val_o
);

  localparam int unsigned Levels = $clog2(Positions);

  logic [Levels:0][Positions-1:0] pre;

  // Log-depth inclusive prefix OR
  always_comb begin
    pre[0] = flags_i;
    for (int l = 0; l < Levels; l++) begin
      for (int i = 0; i < Positions; i++) begin
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
        end else begin
          pre[l+1][i] = pre[l][i];
        end
      end
    end
  end

  // Positions past the first set flag, and the first one itself
  assign after_o = {pre[Levels][Positions-2:0], 1'b0};
  assign first_o = flags_i & ~after_o;

  // AND-OR reduction of the one-hot
  always_comb begin
    idx_o = '0;
    val_o = '0;
    for (int i = 0; i < Positions; i++) begin
      idx_o = idx_o | (first_o[i] ? IdxBits'(i) : '0);
      val_o = val_o | (first_o[i] ? vals_i[i] : '0);
    end
  end

endmodule

// ===== sv/interval_gap_reservation.sv =====
// Interval gap reservation: top level with sequencer and row of table cells
//
// Keeps one resource's busy intervals sorted by start time in a row of cells.
// Input channel s_axis carries one request item (query, reserve or clear);
// output channel m_axis returns exactly one result item per request.
// An item is accepted when the block is idle; the search runs as two
// first-set passes over the cell row (skip to the bound, then first fitting
// gap), followed by a commit cycle that shifts the row, extends an entry or
// empties the table. The sequencer steps through evaluate, select, fit,
// select and commit over the cell row and takes no new item until the result
// of the last one has gone into the output register.
// The result sits in an output register; the next item may be accepted while
// it waits. If the receiver stalls, the finished item after it waits in the
// sequencer until the register is taken, and no further item is accepted.
// Reset empties the table at once (fill count to zero); stored intervals
// beyond the fill count are never looked at.
module interval_gap_reservation import igr_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned TIME_BITS   = 32,
  localparam int unsigned CntBits    = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned InBits     = ModeBits + 2 * TIME_BITS + CntBits,
  localparam int unsigned InW        = ((InBits + 7) / 8) * 8,
  localparam int unsigned OutBits    = TIME_BITS + 2 * CntBits + StatusBits + 1,
  localparam int unsigned OutW       = ((OutBits + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // mode, earliest_time, length, search_from
  input  logic [InW-1:0]  s_axis_tdata_i,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  // start_time, slot_index, status, merged, entries_used
  output logic [OutW-1:0] m_axis_tdata_o
);

  localparam int unsigned Positions = TABLE_DEPTH + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EVAL, ST_FIND1, ST_FIT, ST_FIND2, ST_COMMIT, ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic [CntBits-1:0] used_q, used_d;
  logic               out_valid_q, out_valid_d;

  // Item registers
  logic [ModeBits-1:0]  mode_q;
  logic [TIME_BITS-1:0] bound_q, len_q;
  logic [CntBits-1:0]   first_q;

  // Search results
  logic [TIME_BITS-1:0] p1_q, prevf_q, endcur_q;
  logic [Positions-1:0] is_k1_q, after_k1_q, is_cur_q, after_cur_q;
  logic [CntBits-1:0]   cur_q;

  // Result registers
  logic [TIME_BITS-1:0]  res_start_q;
  logic [CntBits-1:0]    res_slot_q, res_used_q;
  logic [StatusBits-1:0] res_status_q;
  logic                  res_merged_q;
  logic [OutBits-1:0]    out_data_q;

  // Input field views
  logic [ModeBits-1:0]  in_mode;
  logic [TIME_BITS-1:0] in_bound, in_len;
  logic [CntBits-1:0]   in_from, in_first;
  logic                 in_fire, out_load;

  // Cell row wiring
  logic [TABLE_DEPTH-1:0][TIME_BITS-1:0] cell_start, cell_end, start_prev;
  logic [Positions-1:0][TIME_BITS-1:0]   end_prev;
  logic [TABLE_DEPTH-1:0]                cell_sel1, cell_cand;
  igr_cell_ctrl_t                        cell_ctrl;

  // Select outputs
  logic [Positions-1:0] sel_flags, sel_first, sel_after;
  logic [CntBits-1:0]   sel_idx;
  logic [TIME_BITS-1:0] sel_val, p1_c, prevf_c;

  // Commit
  logic [TIME_BITS-1:0] start_c;
  logic [TIME_BITS:0]   fin_c;
  logic                 ovf_c, reserve_c, clear_c, full_c, do_merge, do_ins;
  igr_status_e          status_c;

  // Input unpacking
  assign in_mode  = s_axis_tdata_i[ModeBits-1:0];
  assign in_bound = s_axis_tdata_i[ModeBits +: TIME_BITS];
  assign in_len   = s_axis_tdata_i[ModeBits + TIME_BITS +: TIME_BITS];
  assign in_from  = s_axis_tdata_i[ModeBits + 2 * TIME_BITS +: CntBits];
  assign in_first = (in_from > used_q) ? used_q : in_from;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);

  // Neighbour data along the row
  assign end_prev[0] = '0;
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    assign end_prev[g+1] = cell_end[g];
    if (g == 0) begin : g_head
      assign start_prev[g] = '0;
    end else begin : g_body
      assign start_prev[g] = cell_start[g-1];
    end

    igr_cell #(
      .Index    (g),
      .TimeBits (TIME_BITS),
      .CntBits  (CntBits)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl),
      .used_i        (used_q),
      .first_i       (first_q),
      .bound_i       (bound_q),
      .len_i         (len_q),
      .p1_i          (p1_q),
      .new_start_i   (start_c),
      .new_end_i     (fin_c[TIME_BITS-1:0]),
      .prev_start_i  (start_prev[g]),
      .prev_end_i    (end_prev[g]),
      .is_k1_i       (is_k1_q[g]),
      .after_k1_i    (after_k1_q[g]),
      .is_cur_i      (is_cur_q[g]),
      .after_cur_i   (after_cur_q[g]),
      .next_is_cur_i (is_cur_q[g+1]),
      .start_o       (cell_start[g]),
      .end_o         (cell_end[g]),
      .sel1_o        (cell_sel1[g]),
      .cand_o        (cell_cand[g])
    );
  end

  // Flags for the select: the fill position always stops the search
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sel_flags[i] = ((state_q == ST_FIND1) ? cell_sel1[i] : cell_cand[i]) ||
                     (CntBits'(i) == used_q);
    end
    sel_flags[TABLE_DEPTH] = (used_q == CntBits'(TABLE_DEPTH));
  end

  igr_sel #(
    .Positions (Positions),
    .TimeBits  (TIME_BITS),
    .IdxBits   (CntBits)
  ) u_sel (
    .flags_i (sel_flags),
    .vals_i  (end_prev),
    .first_o (sel_first),
    .after_o (sel_after),
    .idx_o   (sel_idx),
    .val_o   (sel_val)
  );

  // Running finish after the skip, and finish before the chosen gap
  assign p1_c    = (sel_val >= bound_q) ? sel_val : bound_q;
  assign prevf_c = (|(sel_first & is_k1_q)) ? p1_q : sel_val;

  // Commit decision
  always_comb begin
    start_c   = (prevf_q >= bound_q) ? prevf_q : bound_q;
    fin_c     = {1'b0, start_c} + {1'b0, len_q};
    ovf_c     = fin_c[TIME_BITS];
    reserve_c = (mode_q == MODE_RESERVE);
    clear_c   = (mode_q == MODE_CLEAR);
    full_c    = (used_q == CntBits'(TABLE_DEPTH));
    do_merge  = reserve_c && !ovf_c && !is_cur_q[0] && (endcur_q == start_c);
    do_ins    = reserve_c && !ovf_c && !do_merge && !full_c;
    priority if (ovf_c) begin
      status_c = STATUS_OVERFLOW;
    end else if (reserve_c && !do_merge && full_c) begin
      status_c = STATUS_FULL;
    end else begin
      status_c = STATUS_OK;
    end
  end

  assign cell_ctrl.eval  = (state_q == ST_EVAL);
  assign cell_ctrl.fit   = (state_q == ST_FIT);
  assign cell_ctrl.ins   = (state_q == ST_COMMIT) && do_ins;
  assign cell_ctrl.merge = (state_q == ST_COMMIT) && do_merge;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_EVAL;
      ST_EVAL:   state_d = ST_FIND1;
      ST_FIND1:  state_d = ST_FIT;
      ST_FIT:    state_d = ST_FIND2;
      ST_FIND2:  state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_DONE;
      ST_DONE:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Fill count and output valid
  always_comb begin
    used_d = used_q;
    if (state_q == ST_COMMIT) begin
      if (clear_c) begin
        used_d = '0;
      end else if (do_ins) begin
        used_d = used_q + 1'b1;
      end
    end
    out_valid_d = (out_valid_q && !m_axis_tready_i) || out_load;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item, search and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= in_mode;
      bound_q <= in_bound;
      len_q   <= in_len;
      first_q <= in_first;
    end
    if (state_q == ST_FIND1) begin
      p1_q       <= p1_c;
      is_k1_q    <= sel_first;
      after_k1_q <= sel_after;
    end
    if (state_q == ST_FIND2) begin
      cur_q       <= sel_idx;
      is_cur_q    <= sel_first;
      after_cur_q <= sel_after;
      endcur_q    <= sel_val;
      prevf_q     <= prevf_c;
    end
    if (state_q == ST_COMMIT) begin
      if (clear_c) begin
        res_start_q  <= '0;
        res_slot_q   <= '0;
        res_status_q <= STATUS_OK;
        res_merged_q <= 1'b0;
      end else begin
        res_start_q  <= start_c;
        res_slot_q   <= cur_q;
        res_status_q <= status_c;
        res_merged_q <= do_merge;
      end
      res_used_q <= used_d;
    end
    if (out_load) begin
      out_data_q <= {res_used_q, res_merged_q, res_status_q, res_slot_q, res_start_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutW'(out_data_q);

endmodule

// ===== sv/igr_checker.sv =====
// Port-level assertions for the interval gap reservation block, with bind
`include "interval_gap_reservation_assert.svh"

module igr_checker import igr_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned TIME_BITS   = 32,
  localparam int unsigned CntBits    = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned InBits     = ModeBits + 2 * TIME_BITS + CntBits,
  localparam int unsigned InW        = ((InBits + 7) / 8) * 8,
  localparam int unsigned OutBits    = TIME_BITS + 2 * CntBits + StatusBits + 1,
  localparam int unsigned OutW       = ((OutBits + 7) / 8) * 8
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_tvalid_i,
  input logic            s_tready_i,
  // mode, earliest_time, length, search_from
  input logic [InW-1:0]  s_tdata_i,
  input logic            m_tvalid_i,
  input logic            m_tready_i,
  // start_time, slot_index, status, merged, entries_used
  input logic [OutW-1:0] m_tdata_i
);

  logic [CntBits-1:0]    out_slot, out_used;
  logic [StatusBits-1:0] out_status;
  logic                  out_merged;
  logic                  in_fire;
  logic                  m_stall;
  logic                  bounds_ok;

  assign out_slot   = m_tdata_i[TIME_BITS +: CntBits];
  assign out_status = m_tdata_i[TIME_BITS + CntBits +: StatusBits];
  assign out_merged = m_tdata_i[TIME_BITS + CntBits + StatusBits];
  assign out_used   = m_tdata_i[TIME_BITS + CntBits + StatusBits + 1 +: CntBits];
  assign in_fire    = s_tvalid_i && s_tready_i && (s_tdata_i[0] || !s_tdata_i[0]);
  assign m_stall    = m_tvalid_i && !m_tready_i;
  assign bounds_ok  = (out_slot <= out_used) && (out_used <= CntBits'(TABLE_DEPTH));

  // A stalled result holds
  `IGR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_stall, m_tvalid_i && $stable(m_tdata_i))

  // One item in the search at a time
  `IGR_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_fire, !s_tready_i)

  // A merge is always a successful reservation
  `IGR_ASSERT_SAME(a_merge_ok, clk_i, rst_ni, m_tvalid_i && out_merged, out_status == STATUS_OK)

  // Slot lies within the table and the fill count within the depth
  `IGR_ASSERT_SAME(a_slot_bound, clk_i, rst_ni, m_tvalid_i, bounds_ok)

endmodule

bind interval_gap_reservation igr_checker #(
  .TABLE_DEPTH (TABLE_DEPTH),
  .TIME_BITS   (TIME_BITS)
) u_igr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .s_tdata_i  (s_axis_tdata_i),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);

// ===== sim/interval_gap_reservation_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the interval gap reservation block
module interval_gap_reservation_test;
  import igr_pkg::*;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned InW        = 80;
  localparam int unsigned OutW       = 56;
  localparam longint unsigned TimeMax = 64'hFFFF_FFFF;
  localparam int unsigned ItemTarget = 1900;
  localparam int unsigned CycleLimit = 1_500_000;
  // mode three is unused by the block and behaves as a query
  localparam logic [ModeBits-1:0] MODE_UNUSED = 2'd3;

  // Request item, packed with mode in the lowest bits as on s_axis tdata
  typedef struct packed {
    logic [6:0]          search_from;
    logic [31:0]         length;
    logic [31:0]         earliest;
    logic [ModeBits-1:0] mode;
  } request_t;

  // Result item, packed with start_time in the lowest bits as on m_axis tdata
  typedef struct packed {
    logic [6:0]  entries_used;
    logic        merged;
    igr_status_e status;
    logic [6:0]  slot_index;
    logic [31:0] start_time;
  } slot_result_t;

  // Busy table mirror plus queue of predicted slot results
  class gap_table_scoreboard;
    longint unsigned busy_lo[TableDepth];
    longint unsigned busy_hi[TableDepth];
    int unsigned     fill;
    slot_result_t    pending_slots[$];
    int unsigned     mismatch_count;
    int unsigned     results_checked;
    int unsigned     merges_seen;
    int unsigned     full_seen;
    int unsigned     overflow_seen;

    // Work out the slot for one request and update the mirrored table
    function slot_result_t find_gap_slot(request_t rq);
      slot_result_t    r;
      longint unsigned bound, need, prev, start;
      int unsigned     pos;
      r = '0;
      if (rq.mode == MODE_CLEAR) begin
        fill = 0;
        return r;
      end
      bound = 64'(rq.earliest);
      need  = 64'(rq.length);
      // a search start past the fill count saturates to the fill count
      pos   = (32'(rq.search_from) > fill) ? fill : 32'(rq.search_from);
      prev  = (pos > 0) ? busy_hi[pos-1] : 0;
      // skip intervals that open before the bound
      while (pos < fill && busy_lo[pos] < bound) begin
        prev = busy_hi[pos];
        pos++;
      end
      if (prev < bound) prev = bound;
      // first gap wide enough; a gap closing before the running finish is too small
      while (pos < fill && !(busy_lo[pos] >= prev && busy_lo[pos] - prev >= need)) begin
        prev = busy_hi[pos];
        pos++;
      end
      start    = (prev > bound) ? prev : bound;
      r.status = STATUS_OK;
      if (need > TimeMax - start) begin
        r.status = STATUS_OVERFLOW;
      end else if (rq.mode == MODE_RESERVE) begin
        // extend the predecessor if it ends at our start, even when full
        if (pos > 0 && busy_hi[pos-1] == start) begin
          busy_hi[pos-1] = start + need;
          r.merged       = 1'b1;
        end else if (fill >= TableDepth) begin
          r.status = STATUS_FULL;
        end else begin
          for (int unsigned i = fill; i > pos; i--) begin
            busy_lo[i] = busy_lo[i-1];
            busy_hi[i] = busy_hi[i-1];
          end
          busy_lo[pos] = start;
          busy_hi[pos] = start + need;
          fill++;
        end
      end
      r.start_time   = start[31:0];
      r.slot_index   = pos[6:0];
      r.entries_used = fill[6:0];
      return r;
    endfunction

    function void note_request(request_t rq);
      slot_result_t want;
      want = find_gap_slot(rq);
      if (want.merged) merges_seen++;
      if (want.status == STATUS_FULL) full_seen++;
      if (want.status == STATUS_OVERFLOW) overflow_seen++;
      pending_slots = {pending_slots, want};
    endfunction

    function int unsigned pending();
      return pending_slots.size();
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic [OutW-1:0] data);
      slot_result_t got, want;
      got = slot_result_t'(data[$bits(slot_result_t)-1:0]);
      if (pending_slots.size() == 0) begin
        report_mismatch($sformatf("result %h with none outstanding", data));
        return;
      end
      want = pending_slots.pop_front();
      results_checked++;
      if (got.start_time != want.start_time)
        report_mismatch($sformatf("item %0d start_time %0d, want %0d",
                                  results_checked, got.start_time, want.start_time));
      if (got.slot_index != want.slot_index)
        report_mismatch($sformatf("item %0d slot_index %0d, want %0d",
                                  results_checked, got.slot_index, want.slot_index));
      if (got.status != want.status)
        report_mismatch($sformatf("item %0d status %0d, want %0d",
                                  results_checked, got.status, want.status));
      if (got.merged != want.merged)
        report_mismatch($sformatf("item %0d merged %0d, want %0d",
                                  results_checked, got.merged, want.merged));
      if (got.entries_used != want.entries_used)
        report_mismatch($sformatf("item %0d entries_used %0d, want %0d",
                                  results_checked, got.entries_used, want.entries_used));
    endtask
  endclass

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic [InW-1:0]  s_axis_tdata  = '0;
  logic            m_axis_tready = 1'b0;
  logic            s_axis_tready;
  logic            m_axis_tvalid;
  logic [OutW-1:0] m_axis_tdata;

  gap_table_scoreboard sb;
  int unsigned         items_sent;
  int unsigned         cycle_count;
  bit                  steady_tx;

  interval_gap_reservation i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  // Drive one item from a falling edge, return at the falling edge after acceptance
  task automatic send_request(logic [ModeBits-1:0] mode, logic [31:0] earliest,
                              logic [31:0] length, logic [6:0] from);
    request_t    rq;
    int unsigned gap;
    rq  = '{search_from: from, length: length, earliest: earliest, mode: mode};
    gap = steady_tx ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InW - $bits(request_t)){1'b0}}, rq};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(rq);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  // Result side: random stalls with occasional long ready stretches
  initial begin
    int unsigned stall, run;
    @(posedge rst_ni);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      repeat (run) @(negedge clk_i);
    end
  end

  // Check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[interval_gap_reservation] ERROR");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int unsigned         sel, r, p, span, base, count;
    logic [31:0]         t, len;
    logic [ModeBits-1:0] mode;
    int unsigned         order[$];
    sb = new();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: edges of the fields, each mode and the corner cases
    send_request(MODE_QUERY, 0, 0, 0);                          // empty table
    send_request(MODE_RESERVE, 100, 50, 0);
    send_request(MODE_RESERVE, 150, 10, 0);                     // touches predecessor
    send_request(MODE_RESERVE, 0, 100, 0);                      // touches successor only
    send_request(MODE_RESERVE, 0, 5, 0);                        // too small gap, merges at end
    send_request(MODE_RESERVE, 300, 0, 0);                      // zero length
    send_request(MODE_QUERY, 120, 30, 1);                       // skip from mid table
    send_request(MODE_QUERY, 0, 20, 7'h7F);                     // search start saturates
    send_request(MODE_QUERY, 0, 20, 64);
    send_request(MODE_QUERY, 32'hFFFF_FFF0, 32'h20, 0);         // end overflow
    send_request(MODE_RESERVE, 32'hFFFF_FFF0, 32'h20, 0);
    send_request(MODE_QUERY, 0, 32'hFFFF_FFFF, 0);
    send_request(MODE_RESERVE, 32'hFFFF_FFFF, 0, 0);            // at the top of time
    send_request(MODE_RESERVE, 32'hFFFF_FFF0, 32'h0F, 0);       // ends exactly at the top
    send_request(MODE_UNUSED, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 7'h55);
    send_request(MODE_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F);
    send_request(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F);
    send_request(MODE_QUERY, 10, 10, 3);
    wait_for_results();

    // random episodes
    while (items_sent < ItemTarget) begin
      steady_tx = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        // build a schedule: mostly reservations, often starting at an existing end
        case ($urandom_range(0, 2))
          0:       span = 256;
          1:       span = 65536;
          default: span = 1 << 24;
        endcase
        if ($urandom_range(0, 1)) send_request(MODE_CLEAR, $urandom, $urandom, 0);
        count = $urandom_range(8, 40);
        repeat (count) begin
          r = $urandom_range(0, 99);
          if (sb.fill > 0 && $urandom_range(0, 9) < 4)
            t = 32'(sb.busy_hi[$urandom_range(0, sb.fill - 1)]);
          else
            t = $urandom_range(0, span);
          len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, span / 16);
          p   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : 0;
          if (r < 2) mode = MODE_CLEAR;
          else if (r < 66) mode = MODE_RESERVE;
          else if (r < 96) mode = MODE_QUERY;
          else mode = MODE_UNUSED;
          send_request(mode, t, len, 7'(p));
        end
      end else if (sel < 70) begin
        // fill the table in shuffled order, then probe it while full
        send_request(MODE_CLEAR, 0, 0, 0);
        order.delete();
        for (int unsigned i = 0; i < TableDepth; i++) order = {order, i};
        order.shuffle();
        base = $urandom_range(0, 1 << 20);
        foreach (order[k]) send_request(MODE_RESERVE, base + order[k] * 16, 8, 0);
        repeat (3) begin
          p = $urandom_range(0, TableDepth - 1);
          send_request(MODE_RESERVE, base + p * 16 + 8, $urandom_range(1, 4), 0);
          send_request(MODE_RESERVE, base + p * 16 + 14, 1, 0);
          send_request(MODE_QUERY, $urandom_range(0, base + 1100), $urandom_range(0, 40),
                       7'($urandom_range(0, 127)));
        end
        send_request(MODE_RESERVE, base + 2000, 5, 0);
      end else if (sel < 85) begin
        // noise over the whole field ranges
        count = $urandom_range(5, 20);
        repeat (count)
          send_request(2'($urandom_range(0, 3)), $urandom, $urandom,
                       7'($urandom_range(0, 127)));
      end else begin
        // near the top of the time range
        count = $urandom_range(4, 12);
        repeat (count) begin
          t   = 32'hFFFF_FFFF - $urandom_range(0, 4096);
          len = $urandom_range(0, 1) ? $urandom_range(0, 8192) : $urandom;
          p   = $urandom_range(0, 1) ? 0 : $urandom_range(0, 127);
          send_request($urandom_range(0, 1) ? MODE_RESERVE : MODE_QUERY, t, len, 7'(p));
        end
      end
      if ($urandom_range(0, 4) == 0) wait_for_results();
    end
    s_axis_tvalid <= 1'b0;

    // drain and let any stray result show up
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d results over %0d cycles.",
             items_sent, sb.results_checked, cycle_count);
    $display("Seen: %0d merges, %0d full-table refusals, %0d overflows; %0d mismatches.",
             sb.merges_seen, sb.full_seen, sb.overflow_seen, sb.mismatch_count);
    if (sb.mismatch_count == 0) begin
      $display("[interval_gap_reservation] OK");
    end else begin
      $display("[interval_gap_reservation] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/igr_pkg.sv
sv/igr_cell.sv
sv/igr_sel.sv
sv/interval_gap_reservation.sv
sv/igr_checker.sv
sim/interval_gap_reservation_test.sv
